[rtl/midi_note_voice_tracker_defines.svh]
// Assertion macros used by the voice tracker top level.
`ifndef MIDI_NOTE_VOICE_TRACKER_DEFINES_SVH
`define MIDI_NOTE_VOICE_TRACKER_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define MNVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define MNVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mnvt_pkg.sv]
// Types and constants shared by the MIDI note voice tracker modules.
`timescale 1ns / 1ps

package mnvt_pkg;

    localparam int BYTE_W  = 8;
    localparam int CH_W    = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int SUM_W   = 12;
    localparam int TOT_W   = 11;
    localparam int ELONG_W = 12;

    localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] STATUS_NOTE = 8'h80;
    localparam logic [BYTE_W-1:0] CHAN_MASK   = 8'h0F;
    localparam logic [BYTE_W-1:0] ON_MASK     = 8'h10;
    localparam logic [BYTE_W-1:0] CLEAR_BYTE  = 8'hFF;
    localparam logic [VEL_W-1:0]  DATA_MASK   = 7'h7F;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_NOTE   = 2'd1,
        PH_VEL    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              is_on;
        logic [CH_W-1:0]   ch;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_READ  = 3'd1,
        S_CALC  = 3'd2,
        S_CLEAR = 3'd3,
        S_EMIT  = 3'd4
    } t_state;

endpackage

[rtl/midi_note_voice_tracker.sv]
// Top level of the MIDI note voice tracker: sequencer, state memories and result register.
`timescale 1ns / 1ps
`include "midi_note_voice_tracker_defines.svh"

// A byte that does not complete a message is accepted in the idle state. The third byte of a note
// message is accepted with the memory reads issued, the read data returns in the read state,
// then the update is written back to both memories while the result is loaded into the
// output register (held back while a previous result is still waiting there). A clear
// byte (0xFF at status position) and reset both start a clearing pass over the channel/note
// velocity memory, one entry per cycle, CHANNELS*NOTES entries (2048 at the defaults), during
// which no byte is accepted; after a clear byte the emit state loads the clear result once
// the output register is free. Per-note totals live in a second memory that the same pass clears.
module midi_note_voice_tracker #(
    parameter int CHANNELS = 16,
    parameter int NOTES    = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mnvt_pkg::BYTE_W-1:0]         i_midi_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_kind,
    output logic [mnvt_pkg::NOTE_W-1:0]         o_note,
    output logic [mnvt_pkg::TOT_W-1:0]          o_total_velocity,
    output logic signed [mnvt_pkg::ELONG_W-1:0] o_elongation
);

    localparam int DEPTH = CHANNELS * NOTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int NDW   = mnvt_pkg::SUM_W + mnvt_pkg::ELONG_W;

    mnvt_pkg::t_cmd   w_cmd;
    mnvt_pkg::t_cmd   r_cmd;
    mnvt_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic             r_emit_clr, n_emit_clr;
    logic [AW-1:0]    r_vaddr;

    logic             w_accept;
    logic             w_in_range;
    logic [AW-1:0]    w_vaddr;
    logic             w_out_free;
    logic             w_rd_en;
    logic             w_load_upd;
    logic             w_load_clr;

    logic                        w_vel_we;
    logic [AW-1:0]               w_vel_waddr;
    logic [mnvt_pkg::VEL_W-1:0]  w_vel_wdata;
    logic [mnvt_pkg::VEL_W-1:0]  w_vel_rdata;
    logic                        w_note_we;
    logic [NW-1:0]               w_note_waddr;
    logic [NDW-1:0]              w_note_wdata;
    logic [NDW-1:0]              w_note_rdata;

    logic [mnvt_pkg::VEL_W-1:0]          w_new_vel;
    logic signed [mnvt_pkg::SUM_W-1:0]   w_delta;
    logic signed [mnvt_pkg::SUM_W-1:0]   w_old_sum;
    logic signed [mnvt_pkg::SUM_W-1:0]   w_new_sum;
    logic signed [mnvt_pkg::ELONG_W-1:0] w_old_amp;
    logic signed [mnvt_pkg::ELONG_W-1:0] w_new_amp;

    logic                                r_out_valid;
    logic                                r_out_kind;
    logic [mnvt_pkg::NOTE_W-1:0]         r_out_note;
    logic [mnvt_pkg::TOT_W-1:0]          r_out_total;
    logic signed [mnvt_pkg::ELONG_W-1:0] r_out_elong;

    mnvt_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_midi_byte),
        .i_accept (w_accept),
        .o_cmd    (w_cmd)
    );

    mnvt_ram #(
        .WIDTH (mnvt_pkg::VEL_W),
        .DEPTH (DEPTH)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (w_vel_we),
        .i_waddr (w_vel_waddr),
        .i_wdata (w_vel_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_vaddr),
        .o_rdata (w_vel_rdata)
    );

    mnvt_ram #(
        .WIDTH (NDW),
        .DEPTH (NOTES)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (w_note_we),
        .i_waddr (w_note_waddr),
        .i_wdata (w_note_wdata),
        .i_re    (w_rd_en),
        .i_raddr (NW'(w_cmd.note)),
        .o_rdata (w_note_rdata)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (32'(w_cmd.ch) < CHANNELS) && (32'(w_cmd.note) < NOTES);
    assign w_vaddr    = AW'(32'(w_cmd.ch) * NOTES + 32'(w_cmd.note));
    assign w_out_free = !r_out_valid || i_out_ready;

    // Read-modify-write arithmetic on the registered memory outputs.
    assign w_new_vel = r_cmd.is_on ? r_cmd.vel : '0;
    assign w_delta   = $signed({5'b0, w_new_vel}) - $signed({5'b0, w_vel_rdata});
    assign w_old_sum = $signed(w_note_rdata[NDW-1 -: mnvt_pkg::SUM_W]);
    assign w_old_amp = $signed(w_note_rdata[mnvt_pkg::ELONG_W-1:0]);
    assign w_new_sum = w_old_sum + w_delta;

    // The elongation keeps its sign; its magnitude tracks the summed velocity.
    always_comb begin
        if (w_old_amp > 0) begin
            w_new_amp = w_old_amp + w_delta;
        end else if (w_old_amp < 0) begin
            w_new_amp = w_old_amp - w_delta;
        end else begin
            w_new_amp = w_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mnvt_pkg::S_CLEAR;
            r_cnt      <= '0;
            r_emit_clr <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_emit_clr <= n_emit_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_cmd   <= w_cmd;
            r_vaddr <= w_vaddr;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_emit_clr   = r_emit_clr;
        o_in_ready   = 1'b0;
        w_rd_en      = 1'b0;
        w_load_upd   = 1'b0;
        w_load_clr   = 1'b0;
        w_vel_we     = 1'b0;
        w_vel_waddr  = r_vaddr;
        w_vel_wdata  = w_new_vel;
        w_note_we    = 1'b0;
        w_note_waddr = NW'(r_cmd.note);
        w_note_wdata = {w_new_sum, w_new_amp};
        case (r_state)
            mnvt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (w_cmd.kind)
                        mnvt_pkg::CMD_NOTE: begin
                            if (w_in_range) begin
                                w_rd_en = 1'b1;
                                n_state = mnvt_pkg::S_READ;
                            end
                        end
                        mnvt_pkg::CMD_CLEAR: begin
                            n_cnt      = '0;
                            n_emit_clr = 1'b1;
                            n_state    = mnvt_pkg::S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mnvt_pkg::S_READ: begin
                n_state = mnvt_pkg::S_CALC;
            end
            mnvt_pkg::S_CALC: begin
                // The read data stays registered in the RAMs while the result waits.
                if (w_out_free) begin
                    w_vel_we   = 1'b1;
                    w_note_we  = 1'b1;
                    w_load_upd = 1'b1;
                    n_state    = mnvt_pkg::S_IDLE;
                end
            end
            mnvt_pkg::S_CLEAR: begin
                w_vel_we     = 1'b1;
                w_vel_waddr  = r_cnt;
                w_vel_wdata  = '0;
                w_note_we    = 1'b1;
                w_note_waddr = NW'(r_cnt);
                w_note_wdata = '0;
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = r_emit_clr ? mnvt_pkg::S_EMIT : mnvt_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            mnvt_pkg::S_EMIT: begin
                if (w_out_free) begin
                    w_load_clr = 1'b1;
                    n_emit_clr = 1'b0;
                    n_state    = mnvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mnvt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_upd || w_load_clr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_upd) begin
            r_out_kind  <= mnvt_pkg::KIND_UPDATE;
            r_out_note  <= r_cmd.note;
            r_out_total <= w_new_sum[mnvt_pkg::TOT_W-1:0];
            r_out_elong <= w_new_amp;
        end else if (w_load_clr) begin
            r_out_kind  <= mnvt_pkg::KIND_CLEAR;
            r_out_note  <= '0;
            r_out_total <= '0;
            r_out_elong <= '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_note           = r_out_note;
    assign o_total_velocity = r_out_total;
    assign o_elongation     = r_out_elong;

    `MNVT_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == mnvt_pkg::S_CLEAR, !o_in_ready, "byte accepted during clearing pass")
    `MNVT_ASSERT_NOW(a_elong_tracks_total, i_clk, i_rst_n, o_out_valid && (o_kind == mnvt_pkg::KIND_UPDATE), (o_elongation == $signed({1'b0, o_total_velocity})) || (o_elongation == -$signed({1'b0, o_total_velocity})), "elongation magnitude differs from total velocity")
    `MNVT_ASSERT_NOW(a_clear_result_zero, i_clk, i_rst_n, o_out_valid && (o_kind == mnvt_pkg::KIND_CLEAR), (o_note == '0) && (o_total_velocity == '0) && (o_elongation == '0), "clear result carries nonzero fields")
    `MNVT_ASSERT_NEXT(a_read_then_calc, i_clk, i_rst_n, r_state == mnvt_pkg::S_READ, r_state == mnvt_pkg::S_CALC, "read cycle not followed by update cycle")

endmodule

[rtl/mnvt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mnvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mnvt_parser.sv]
// Byte-level MIDI parser for note-on, note-off and the clear status byte.
`timescale 1ns / 1ps

module mnvt_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mnvt_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_accept,
    output mnvt_pkg::t_cmd                o_cmd
);

    mnvt_pkg::t_phase             r_phase, n_phase;
    logic [mnvt_pkg::CH_W-1:0]    r_ch, n_ch;
    logic                         r_on, n_on;
    logic [mnvt_pkg::NOTE_W-1:0]  r_note, n_note;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mnvt_pkg::PH_STATUS;
            r_ch    <= '0;
            r_on    <= 1'b0;
            r_note  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_ch    <= n_ch;
            r_on    <= n_on;
            r_note  <= n_note;
        end
    end

    always_comb begin
        n_phase     = mnvt_pkg::PH_STATUS;
        n_ch        = r_ch;
        n_on        = r_on;
        n_note      = r_note;
        o_cmd.kind  = mnvt_pkg::CMD_NONE;
        o_cmd.is_on = r_on;
        o_cmd.ch    = r_ch;
        o_cmd.note  = r_note;
        o_cmd.vel   = i_byte[mnvt_pkg::VEL_W-1:0] & mnvt_pkg::DATA_MASK;
        case (r_phase)
            mnvt_pkg::PH_NOTE: begin
                n_note  = i_byte[mnvt_pkg::NOTE_W-1:0];
                n_phase = mnvt_pkg::PH_VEL;
            end
            mnvt_pkg::PH_VEL: begin
                o_cmd.kind = mnvt_pkg::CMD_NOTE;
            end
            default: begin
                // Waiting for a status byte; data bytes here are dropped.
                if ((i_byte & mnvt_pkg::STATUS_MASK) == mnvt_pkg::STATUS_NOTE) begin
                    n_ch    = mnvt_pkg::CH_W'(i_byte & mnvt_pkg::CHAN_MASK);
                    n_on    = ((i_byte & mnvt_pkg::ON_MASK) != '0);
                    n_phase = mnvt_pkg::PH_NOTE;
                end else if (i_byte == mnvt_pkg::CLEAR_BYTE) begin
                    n_ch       = '0;
                    n_on       = 1'b0;
                    n_note     = '0;
                    o_cmd.kind = mnvt_pkg::CMD_CLEAR;
                end
            end
        endcase
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the MIDI note voice tracker, with its own model of the tracker.
`timescale 1ns / 1ps

module tb_top;
    import mnvt_pkg::*;

    localparam int NUM_CH    = 16;
    localparam int NUM_NOTES = 128;
    localparam int RANDOM_ITEMS = 620;

    typedef struct packed {
        logic                     kind;
        logic [NOTE_W-1:0]        note;
        logic [TOT_W-1:0]         total;
        logic signed [ELONG_W-1:0] elong;
    } t_note_update;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [BYTE_W-1:0]         i_midi_byte = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_kind;
    logic [NOTE_W-1:0]         o_note;
    logic [TOT_W-1:0]          o_total_velocity;
    logic signed [ELONG_W-1:0] o_elongation;

    // Tracker state as the testbench sees it.
    t_phase                    parse_state;
    logic [CH_W-1:0]           open_channel;
    logic                      open_is_on;
    logic [NOTE_W-1:0]         open_note;
    logic [VEL_W-1:0]          held_velocity [NUM_CH][NUM_NOTES];
    logic [SUM_W-1:0]          note_total [NUM_NOTES];
    logic signed [ELONG_W-1:0] note_elong [NUM_NOTES];

    t_note_update pending_updates[$];
    int           error_count = 0;
    int           bytes_sent = 0;
    bit           sender_idles = 1'b0;
    bit           receiver_idles = 1'b0;
    int           stall_left = 0;

    midi_note_voice_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_midi_byte      (i_midi_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_note           (o_note),
        .o_total_velocity (o_total_velocity),
        .o_elongation     (o_elongation)
    );

    always #6 i_clk = ~i_clk;

    task automatic clear_tracker();
        parse_state  = PH_STATUS;
        open_channel = '0;
        open_is_on   = 1'b0;
        open_note    = '0;
        foreach (held_velocity[c, n]) held_velocity[c][n] = '0;
        foreach (note_total[n]) begin
            note_total[n] = '0;
            note_elong[n] = '0;
        end
    endtask

    // Advances the tracker by one byte and queues the update it produces, if any.
    task automatic track_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] masked;
        logic [VEL_W-1:0]  vel;
        int                prev, delta, amp;
        t_note_update      upd;
        masked = b & {1'b0, DATA_MASK};
        case (parse_state)
            PH_NOTE: begin
                open_note   = masked[NOTE_W-1:0];
                parse_state = PH_VEL;
            end
            PH_VEL: begin
                vel         = masked[VEL_W-1:0];
                parse_state = PH_STATUS;
                prev        = held_velocity[open_channel][open_note];
                if (!open_is_on) vel = '0;
                delta = int'(vel) - prev;
                held_velocity[open_channel][open_note] = vel;
                note_total[open_note] = SUM_W'(note_total[open_note] + delta);
                amp = note_elong[open_note];
                if (amp > 0) amp = amp + delta;
                else if (amp < 0) amp = amp - delta;
                else amp = delta;
                note_elong[open_note] = ELONG_W'(amp);
                upd.kind  = KIND_UPDATE;
                upd.note  = open_note;
                upd.total = note_total[open_note][TOT_W-1:0];
                upd.elong = note_elong[open_note];
                pending_updates.push_back(upd);
            end
            default: begin
                parse_state = PH_STATUS;
                if ((b & STATUS_MASK) == STATUS_NOTE) begin
                    masked       = b & CHAN_MASK;
                    open_channel = masked[CH_W-1:0];
                    open_is_on   = (b & ON_MASK) != '0;
                    parse_state  = PH_NOTE;
                end else if (b == CLEAR_BYTE) begin
                    clear_tracker();
                    upd.kind  = KIND_CLEAR;
                    upd.note  = '0;
                    upd.total = '0;
                    upd.elong = '0;
                    pending_updates.push_back(upd);
                end
            end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = sender_idles ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_midi_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_message(input logic on, input int ch, input int note, input int vel);
        send_byte(BYTE_W'(on ? (STATUS_NOTE | ON_MASK | ch) : (STATUS_NOTE | ch)));
        send_byte(BYTE_W'(note));
        send_byte(BYTE_W'(vel));
    endtask

    // Valid stays high after a transaction until the next byte, so a pause drops it first.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random back-pressure and the field-by-field comparison.
    always @(posedge i_clk) begin
        t_note_update exp_upd;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected result: kind %0d note %0d total %0d elongation %0d",
                       o_kind, o_note, o_total_velocity, o_elongation);
                error_count++;
            end else begin
                exp_upd = pending_updates.pop_front();
                if (o_kind !== exp_upd.kind) begin
                    $error("kind: expected %0d, got %0d", exp_upd.kind, o_kind);
                    error_count++;
                end
                if (o_note !== exp_upd.note) begin
                    $error("note: expected %0d, got %0d", exp_upd.note, o_note);
                    error_count++;
                end
                if (o_total_velocity !== exp_upd.total) begin
                    $error("total_velocity: expected %0d, got %0d",
                           exp_upd.total, o_total_velocity);
                    error_count++;
                end
                if (o_elongation !== exp_upd.elong) begin
                    $error("elongation: expected %0d, got %0d", exp_upd.elong, o_elongation);
                    error_count++;
                end
            end
            stall_left = receiver_idles ? $urandom_range(0, 9) : 0;
            i_out_ready <= (stall_left == 0);
        end else if (!i_out_ready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) i_out_ready <= 1'b1;
        end
    end

    task automatic test_directed_cases();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_message(1'b1, 0, 0, 'h7F);
        send_message(1'b1, 15, 127, 'h7F);
        send_message(1'b1, 5, 0, 'h40);
        // Note off ignores its velocity byte.
        send_message(1'b0, 0, 0, 'h33);
        // Note on with zero velocity releases the note.
        send_message(1'b1, 5, 0, 'h00);
        // A data byte and non-note status bytes at message start are ignored.
        send_byte(8'h45);
        send_byte(8'hA3);
        send_byte(8'hC0);
        send_byte(8'hF8);
        send_byte(8'hE7);
        // Bytes with the top bit set inside a message count as data.
        send_byte(8'h91);
        send_byte(8'hFF);
        send_byte(8'h90);
        send_message(1'b0, 15, 127, 'hFF);
        wait_for_results();
        send_byte(CLEAR_BYTE);
        send_message(1'b1, 3, 60, 'h01);
        wait_for_results();
    endtask

    // Every channel plays the same note at full velocity, then releases it.
    task automatic test_full_chord();
        int ch;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (ch = 0; ch < NUM_CH; ch++) send_message(1'b1, ch, 127, 'h7F);
        receiver_idles = 1'b1;
        for (ch = NUM_CH - 1; ch >= 0; ch--) send_message(ch[0], ch, 127, 'h00);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int pick, note, start_count;
        logic [BYTE_W-1:0] status;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            // New idle pattern every hundred bytes, including runs with no idling.
            if (((bytes_sent - start_count) % 100) < 3) begin
                sender_idles   = $urandom_range(0, 2) != 0;
                receiver_idles = $urandom_range(0, 2) != 0;
            end
            pick = $urandom_range(0, 99);
            note = ($urandom_range(0, 9) < 7) ? $urandom_range(60, 63) : $urandom_range(0, 127);
            if (pick < 75) begin
                status = BYTE_W'(STATUS_NOTE | $urandom_range(0, 15));
                if ($urandom_range(0, 99) < 65) status = status | ON_MASK;
                send_byte(status);
                send_byte(BYTE_W'(($urandom_range(0, 9) == 0) ? (note | 'h80) : note));
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                // Message cut short: the next status byte lands in a data slot.
                send_byte(BYTE_W'(STATUS_NOTE | $urandom_range(0, 31)));
                send_byte(BYTE_W'(note));
            end else if (pick < 94) begin
                send_byte(CLEAR_BYTE);
            end else if (pick < 96) begin
                wait_for_results();
            end else begin
                send_byte(BYTE_W'($urandom_range('hA0, 'hFE)));
            end
        end
        wait_for_results();
    endtask

    initial begin
        clear_tracker();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_chord();
        test_random_traffic();
        wait_for_results();
        repeat (64) @(posedge i_clk);
        if (error_count == 0) begin
            $display("midi_note_voice_tracker verification clean");
        end else begin
            $display("midi_note_voice_tracker verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("midi_note_voice_tracker verification failed");
        $finish;
    end

endmodule
